// File: design/bpsa_pkg.sv
// Package for box_position_shape_affinity: widths, register indexes, reset values
// and the 2^(-2^-k) table of the exponential. No dependencies.
`default_nettype none
package bpsa_pkg;
   localparam int COORD_BITS_DEF    = 16;
   localparam int AFFINITY_BITS_DEF = 16;
   localparam int WEIGHT_BITS       = 12;
   localparam int WEIGHT_FRAC       = 8;
   localparam int CSR_IDX_BITS      = 8;
   localparam int FRAC_BITS         = 16;
   localparam int RATIO_BITS        = 24;
   localparam int CLAMP_SHIFT       = RATIO_BITS - FRAC_BITS;
   localparam int SHAPE_Q_BITS      = FRAC_BITS + 1;
   localparam int EXP_BITS          = 24;
   localparam int LOG2E_BITS        = 17;
   localparam int T_BITS            = EXP_BITS + LOG2E_BITS - FRAC_BITS;
   localparam int SHIFT_BITS        = T_BITS - FRAC_BITS;
   localparam int MAX_SHIFT         = 40;
   localparam int DIV_STAGES        = RATIO_BITS;

   localparam logic [LOG2E_BITS-1:0]  LOG2E_Q16 = 17'd94548;
   localparam logic [EXP_BITS-1:0]    EXP_MAX   = {EXP_BITS{1'b1}};
   localparam logic [WEIGHT_BITS-1:0] POSITION_WEIGHT_RST = 12'd128;
   localparam logic [WEIGHT_BITS-1:0] SHAPE_WEIGHT_RST    = 12'd384;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_POSITION_WEIGHT = 8'd0,
      REG_SHAPE_WEIGHT    = 8'd1
   } csr_reg_type;

   // 2^(-2^-(k+1)) in Q0.32
   function automatic logic [31:0] pow2_frac(input logic [3:0] k);
      logic [31:0] v;
      case (k)
         4'd0:  v = 32'd3037000500;
         4'd1:  v = 32'd3611622603;
         4'd2:  v = 32'd3938502376;
         4'd3:  v = 32'd4112874773;
         4'd4:  v = 32'd4202935003;
         4'd5:  v = 32'd4248701965;
         4'd6:  v = 32'd4271771997;
         4'd7:  v = 32'd4283353945;
         4'd8:  v = 32'd4289156690;
         4'd9:  v = 32'd4292061010;
         4'd10: v = 32'd4293513907;
         4'd11: v = 32'd4294240540;
         4'd12: v = 32'd4294603903;
         4'd13: v = 32'd4294785595;
         4'd14: v = 32'd4294876445;
         4'd15: v = 32'd4294921870;
         default: v = 32'd0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

// File: design/bpsa_req_if.sv
// Box pair input channel: valid/ready and the two boxes.
// Standalone; width set by CW.
`default_nettype none
interface bpsa_req_if #(parameter int CW = 16);
   logic          valid;
   logic          ready;
   logic [CW-1:0] det_center_x;
   logic [CW-1:0] det_center_y;
   logic [CW-1:0] det_width;
   logic [CW-1:0] det_height;
   logic [CW-1:0] pred_center_x;
   logic [CW-1:0] pred_center_y;
   logic [CW-1:0] pred_width;
   logic [CW-1:0] pred_height;
   modport source (output valid, det_center_x, det_center_y, det_width, det_height,
                   pred_center_x, pred_center_y, pred_width, pred_height, input ready);
   modport sink (input valid, det_center_x, det_center_y, det_width, det_height,
                 pred_center_x, pred_center_y, pred_width, pred_height, output ready);
endinterface
`default_nettype wire

// File: design/bpsa_rsp_if.sv
// Affinity result channel: valid/ready, affinity and invalid flag.
// Standalone; width set by AW.
`default_nettype none
interface bpsa_rsp_if #(parameter int AW = 16);
   logic          valid;
   logic          ready;
   logic [AW-1:0] affinity;
   logic          invalid_box;
   modport source (output valid, affinity, invalid_box, input ready);
   modport sink (input valid, affinity, invalid_box, output ready);
endinterface
`default_nettype wire

// File: design/bpsa_csr_if.sv
// Register write channel: valid/ready, register index and data.
// Uses bpsa_pkg widths.
`default_nettype none
interface bpsa_csr_if;
   logic                              valid;
   logic                              ready;
   logic [bpsa_pkg::CSR_IDX_BITS-1:0] index;
   logic [bpsa_pkg::WEIGHT_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: design/bpsa_div.sv
// Pipelined restoring divider, one quotient bit per stage, max(QW, LAT) stages.
// Standalone; the caller supplies the top remainder and the low dividend bits.
`default_nettype none
module bpsa_div #(
   parameter int DW  = 16,
   parameter int QW  = 24,
   parameter int LAT = 24
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [DW-1:0] rem_init,
   input  wire logic [QW-1:0] num_lo,
   input  wire logic [DW-1:0] den,
   output logic      [QW-1:0] quo
);
   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] lo_ff  [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] q_ff   [QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [DW-1:0] src_rem, src_den, rem_in;
      logic [QW-1:0] src_lo, src_q, q_in;
      logic [DW:0]   trial, diff;
      logic          ge;
      if (k == 0) begin : g_first
         assign src_rem = rem_init;
         assign src_lo  = num_lo;
         assign src_den = den;
         assign src_q   = '0;
      end else begin : g_next
         assign src_rem = rem_ff[k-1];
         assign src_lo  = lo_ff[k-1];
         assign src_den = den_ff[k-1];
         assign src_q   = q_ff[k-1];
      end
      always_comb begin
         trial  = {src_rem, src_lo[QW-1]};
         ge     = trial >= {1'b0, src_den};
         diff   = trial - {1'b0, src_den};
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         q_in   = {src_q[QW-2:0], ge};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            lo_ff[k]  <= {src_lo[QW-2:0], 1'b0};
            den_ff[k] <= src_den;
            q_ff[k]   <= q_in;
         end
      end
   end

   if (LAT > QW) begin : g_pad
      logic [QW-1:0] dly_ff [LAT-QW];
      always_ff @(posedge clock) begin
         if (en) begin
            dly_ff[0] <= q_ff[QW-1];
            for (int i = 1; i < LAT-QW; i++) dly_ff[i] <= dly_ff[i-1];
         end
      end
      assign quo = dly_ff[LAT-QW-1];
   end else begin : g_nopad
      assign quo = q_ff[QW-1];
   end
endmodule
`default_nettype wire

// File: design/bpsa_exp.sv
// 2^-t evaluator: sixteen table-multiply stages, then shift and round stage.
// Uses bpsa_pkg (pow2_frac table, widths).
`default_nettype none
module bpsa_exp #(
   parameter int AFFINITY_BITS = bpsa_pkg::AFFINITY_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              en,
   input  wire logic [bpsa_pkg::T_BITS-1:0]       t_val,
   output logic      [AFFINITY_BITS-1:0]          aff
);
   import bpsa_pkg::*;

   localparam int DROP = 32 - AFFINITY_BITS;
   localparam int RW   = 34 - DROP;

   logic [31:0]       acc_ff [FRAC_BITS];
   logic              one_ff [FRAC_BITS];
   logic [T_BITS-1:0] t_ff   [FRAC_BITS];
   logic [AFFINITY_BITS-1:0] aff_ff;

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
      logic [31:0]       src_acc, acc_in;
      logic              src_one, one_in;
      logic [T_BITS-1:0] src_t;
      logic [63:0]       prod;
      if (k == 0) begin : g_first
         assign src_acc = '0;
         assign src_one = 1'b1;
         assign src_t   = t_val;
      end else begin : g_next
         assign src_acc = acc_ff[k-1];
         assign src_one = one_ff[k-1];
         assign src_t   = t_ff[k-1];
      end
      always_comb begin
         prod   = src_acc * pow2_frac(4'(k));
         acc_in = src_acc;
         one_in = src_one;
         if (src_t[FRAC_BITS-1-k]) begin
            acc_in = src_one ? pow2_frac(4'(k)) : prod[63:32];
            one_in = 1'b0;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[k] <= acc_in;
            one_ff[k] <= one_in;
            t_ff[k]   <= src_t;
         end
      end
   end

   logic [SHIFT_BITS-1:0] n;
   logic [32:0]           val, shifted;
   logic [33:0]           rnd;
   logic [RW-1:0]         r;
   logic [AFFINITY_BITS-1:0] aff_in;

   always_comb begin
      n       = t_ff[FRAC_BITS-1][T_BITS-1:FRAC_BITS];
      val     = one_ff[FRAC_BITS-1] ? {1'b1, 32'd0} : {1'b0, acc_ff[FRAC_BITS-1]};
      shifted = val >> n;
      rnd     = {1'b0, shifted} + (34'd1 << (DROP - 1));
      r       = rnd[33:DROP];
      if (n > SHIFT_BITS'(MAX_SHIFT)) aff_in = '0;
      else if (r > RW'({AFFINITY_BITS{1'b1}})) aff_in = '1;
      else aff_in = r[AFFINITY_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) aff_ff <= aff_in;
   end
   assign aff = aff_ff;
endmodule
`default_nettype wire

// File: design/box_position_shape_affinity.sv
// Top level of the box position/shape affinity pipeline.
// Uses bpsa_pkg, bpsa_req_if, bpsa_rsp_if, bpsa_csr_if, bpsa_div, bpsa_exp.
//
// One box pair per req word; one rsp word per pair, in order.
// 48 register stages: 1 input stage, 24 divider stages, 5 multiply/sum
// stages, 17 exponential stages, output register; the input stage loads
// at the req accept edge.
// Throughput: one word per cycle while the skid register is empty; the
// pipeline moves as a whole.
// csr writes (index 0 position_weight, 1 shape_weight, others ignored)
// are always ready and are to be made only while the pipeline is empty.
// Reset: empties the pipeline and output buffer, loads weights 0.5 / 1.5.
// rsp stall: the output register holds, one more word goes to a skid
// register, then req.ready drops until the skid drains.
// A zero detection width or height gives affinity 0 with invalid_box set.
`default_nettype none
module box_position_shape_affinity #(
   parameter int COORD_BITS    = bpsa_pkg::COORD_BITS_DEF,
   parameter int AFFINITY_BITS = bpsa_pkg::AFFINITY_BITS_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   bpsa_req_if.sink    req,
   bpsa_rsp_if.source  rsp,
   bpsa_csr_if.sink    csr
);
   import bpsa_pkg::*;

   localparam int CW     = COORD_BITS;
   localparam int P_DIV  = DIV_STAGES;
   localparam int P_EXP  = P_DIV + 6;
   localparam int NSTAGE = P_EXP + FRAC_BITS + 1;

   typedef struct packed {
      logic valid;
      logic inv;
      logic ovx;
      logic ovy;
   } ctl_type;

   logic [WEIGHT_BITS-1:0] pos_weight_ff, shape_weight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_weight_ff   <= POSITION_WEIGHT_RST;
         shape_weight_ff <= SHAPE_WEIGHT_RST;
      end else if (csr.valid && csr.ready) begin
         if (csr.index == REG_POSITION_WEIGHT) pos_weight_ff <= csr.data;
         if (csr.index == REG_SHAPE_WEIGHT) shape_weight_ff <= csr.data;
      end
   end
   assign csr.ready = 1'b1;

   logic en, skid_valid_ff;
   assign en        = !skid_valid_ff;
   assign req.ready = en;

   // input stage
   ctl_type ctl_ff [NSTAGE];
   ctl_type ctl0_in;
   logic [CW-1:0] offx_in, offy_in, adw_in, adh_in;
   logic [CW:0]   denw_in, denh_in;
   logic [CW-1:0] offx_ff, offy_ff, adw_ff, adh_ff, dw_ff, dh_ff;
   logic [CW:0]   denw_ff, denh_ff;

   always_comb begin
      offx_in = (req.det_center_x >= req.pred_center_x) ?
                req.det_center_x - req.pred_center_x : req.pred_center_x - req.det_center_x;
      offy_in = (req.det_center_y >= req.pred_center_y) ?
                req.det_center_y - req.pred_center_y : req.pred_center_y - req.det_center_y;
      adw_in  = (req.det_width >= req.pred_width) ?
                req.det_width - req.pred_width : req.pred_width - req.det_width;
      adh_in  = (req.det_height >= req.pred_height) ?
                req.det_height - req.pred_height : req.pred_height - req.det_height;
      denw_in = {1'b0, req.det_width} + {1'b0, req.pred_width};
      denh_in = {1'b0, req.det_height} + {1'b0, req.pred_height};
      ctl0_in.valid = req.valid;
      ctl0_in.inv   = (req.det_width == '0) || (req.det_height == '0);
      ctl0_in.ovx   = {{CLAMP_SHIFT{1'b0}}, offx_in} >= {req.det_width, {CLAMP_SHIFT{1'b0}}};
      ctl0_in.ovy   = {{CLAMP_SHIFT{1'b0}}, offy_in} >= {req.det_height, {CLAMP_SHIFT{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         offx_ff <= offx_in;
         offy_ff <= offy_in;
         adw_ff  <= adw_in;
         adh_ff  <= adh_in;
         dw_ff   <= req.det_width;
         dh_ff   <= req.det_height;
         denw_ff <= denw_in;
         denh_ff <= denh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTAGE; i++) ctl_ff[i] <= '0;
      end else if (en) begin
         ctl_ff[0] <= ctl0_in;
         for (int i = 1; i < NSTAGE; i++) ctl_ff[i] <= ctl_ff[i-1];
      end
   end

   // dividers
   logic [RATIO_BITS-1:0]   qx, qy;
   logic [SHAPE_Q_BITS-1:0] rw, rh;

   bpsa_div #(.DW(CW), .QW(RATIO_BITS), .LAT(DIV_STAGES)) u_div_x (
      .clock(clock), .en(en),
      .rem_init(offx_ff >> CLAMP_SHIFT),
      .num_lo({offx_ff[CLAMP_SHIFT-1:0], {FRAC_BITS{1'b0}}}),
      .den(dw_ff), .quo(qx));
   bpsa_div #(.DW(CW), .QW(RATIO_BITS), .LAT(DIV_STAGES)) u_div_y (
      .clock(clock), .en(en),
      .rem_init(offy_ff >> CLAMP_SHIFT),
      .num_lo({offy_ff[CLAMP_SHIFT-1:0], {FRAC_BITS{1'b0}}}),
      .den(dh_ff), .quo(qy));
   bpsa_div #(.DW(CW+1), .QW(SHAPE_Q_BITS), .LAT(DIV_STAGES)) u_div_w (
      .clock(clock), .en(en),
      .rem_init({2'b00, adw_ff[CW-1:1]}),
      .num_lo({adw_ff[0], {FRAC_BITS{1'b0}}}),
      .den(denw_ff), .quo(rw));
   bpsa_div #(.DW(CW+1), .QW(SHAPE_Q_BITS), .LAT(DIV_STAGES)) u_div_h (
      .clock(clock), .en(en),
      .rem_init({2'b00, adh_ff[CW-1:1]}),
      .num_lo({adh_ff[0], {FRAC_BITS{1'b0}}}),
      .den(denh_ff), .quo(rh));

   // squares, weights, exponent
   logic [RATIO_BITS-1:0]       qxc, qyc;
   logic [2*RATIO_BITS-1:0]     sqx_prod, sqy_prod;
   logic [31:0]                 sqx_ff, sqy_ff;
   logic [SHAPE_Q_BITS:0]       shp_sum_ff;
   logic [32:0]                 pos_sum_ff;
   logic [SHAPE_Q_BITS+WEIGHT_BITS:0] shp_full;
   logic [SHAPE_Q_BITS+WEIGHT_BITS-WEIGHT_FRAC:0] shp_prod_ff, shp_prod2_ff;
   logic [33+WEIGHT_BITS-1:0]   pos_full;
   logic [33+WEIGHT_BITS-WEIGHT_FRAC-1:0] pos_prod_ff;
   logic [33+WEIGHT_BITS-WEIGHT_FRAC:0]   e_sum;
   logic [EXP_BITS-1:0]         e_ff;
   logic [EXP_BITS+LOG2E_BITS-1:0] t_full;
   logic [T_BITS-1:0]           t_ff;

   always_comb begin
      qxc      = ctl_ff[P_DIV].ovx ? EXP_MAX : qx;
      qyc      = ctl_ff[P_DIV].ovy ? EXP_MAX : qy;
      sqx_prod = qxc * qxc;
      sqy_prod = qyc * qyc;
      shp_full = shp_sum_ff * shape_weight_ff;
      pos_full = pos_sum_ff * pos_weight_ff;
      e_sum    = {1'b0, pos_prod_ff} + (33+WEIGHT_BITS-WEIGHT_FRAC+1)'(shp_prod2_ff);
      t_full   = e_ff * LOG2E_Q16;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff       <= sqx_prod[FRAC_BITS+31:FRAC_BITS];
         sqy_ff       <= sqy_prod[FRAC_BITS+31:FRAC_BITS];
         shp_sum_ff   <= {1'b0, rw} + {1'b0, rh};
         pos_sum_ff   <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
         shp_prod_ff  <= shp_full[SHAPE_Q_BITS+WEIGHT_BITS:WEIGHT_FRAC];
         pos_prod_ff  <= pos_full[33+WEIGHT_BITS-1:WEIGHT_FRAC];
         shp_prod2_ff <= shp_prod_ff;
         e_ff         <= (e_sum > (33+WEIGHT_BITS-WEIGHT_FRAC+1)'(EXP_MAX)) ?
                         EXP_MAX : e_sum[EXP_BITS-1:0];
         t_ff         <= t_full[EXP_BITS+LOG2E_BITS-1:FRAC_BITS];
      end
   end

   logic [AFFINITY_BITS-1:0] exp_aff;

   bpsa_exp #(.AFFINITY_BITS(AFFINITY_BITS)) u_exp (
      .clock(clock), .en(en), .t_val(t_ff), .aff(exp_aff));

   // output register and skid
   logic                     push, new_inv;
   logic [AFFINITY_BITS-1:0] new_aff;
   logic                     out_valid_ff, out_inv_ff, skid_inv_ff;
   logic [AFFINITY_BITS-1:0] out_aff_ff, skid_aff_ff;

   assign push    = en && ctl_ff[NSTAGE-1].valid;
   assign new_inv = ctl_ff[NSTAGE-1].inv;
   assign new_aff = new_inv ? '0 : exp_aff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp.ready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp.ready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_aff_ff <= skid_aff_ff;
            out_inv_ff <= skid_inv_ff;
         end else begin
            out_aff_ff <= new_aff;
            out_inv_ff <= new_inv;
         end
      end else if (push) begin
         skid_aff_ff <= new_aff;
         skid_inv_ff <= new_inv;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.affinity    = out_aff_ff;
   assign rsp.invalid_box = out_inv_ff;

   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff) else $error("skid full while output empty");
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.invalid_box) |-> (rsp.affinity == '0))
      else $error("invalid box with nonzero affinity");
   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (push && out_valid_ff && !rsp.ready) |=> skid_valid_ff)
      else $error("stalled word not captured in skid");
endmodule
`default_nettype wire

// File: dv/tb_bpsa_if.sv
// Testbench types: box pair and affinity word layouts.
// Depends on bpsa_pkg from the design folder.
`default_nettype none
package tb_bpsa_pkg;
   import bpsa_pkg::*;
   typedef struct packed {
      logic [15:0] det_center_x;
      logic [15:0] det_center_y;
      logic [15:0] det_width;
      logic [15:0] det_height;
      logic [15:0] pred_center_x;
      logic [15:0] pred_center_y;
      logic [15:0] pred_width;
      logic [15:0] pred_height;
   } box_pair_type;
   typedef struct packed {
      logic [15:0] affinity;
      logic        invalid_box;
   } affinity_type;
endpackage
`default_nettype wire

// File: dv/tb_box_position_shape_affinity.sv
// Testbench for box_position_shape_affinity: directed table then random box pairs,
// each result checked against an in-bench affinity predictor. Depends on bpsa_pkg,
// the design interfaces, the box_position_shape_affinity top and tb_bpsa_pkg.
`default_nettype none
module tb_box_position_shape_affinity;
   timeunit 1ns;
   timeprecision 1ps;
   import bpsa_pkg::*;
   import tb_bpsa_pkg::*;

   localparam int LATENCY = 47;
   localparam int LIMIT   = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bpsa_req_if #(.CW(16)) req ();
   bpsa_rsp_if #(.AW(16)) rsp ();
   bpsa_csr_if            csr ();

   box_position_shape_affinity i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   logic [11:0]  pos_weight;
   logic [11:0]  shp_weight;
   affinity_type pending_affinity[$];
   int           errors = 0;
   int           cycles = 0;
   int           n_sent = 0;
   int           n_got = 0;
   int           n_invalid = 0;
   int           long_stall = 0;
   bit           stall_en = 1'b0;

   function automatic logic [63:0] abs_diff(logic [63:0] a, logic [63:0] b);
      return a >= b ? a - b : b - a;
   endfunction

   function automatic logic [63:0] sq_offset(logic [63:0] off, logic [63:0] size);
      logic [63:0] q;
      q = (off << 16) / size;
      if (q > 64'hFF_FFFF) q = 64'hFF_FFFF;
      return (q * q) >> 16;
   endfunction

   function automatic logic [63:0] size_diff(logic [63:0] a, logic [63:0] b);
      return (abs_diff(a, b) << 16) / (a + b);
   endfunction

   function automatic logic [15:0] neg_exp(logic [63:0] e);
      logic [31:0] tab[16];
      logic [63:0] t, n, acc, r;
      tab = '{32'd3037000500, 32'd3611622603, 32'd3938502376, 32'd4112874773,
              32'd4202935003, 32'd4248701965, 32'd4271771997, 32'd4283353945,
              32'd4289156690, 32'd4292061010, 32'd4293513907, 32'd4294240540,
              32'd4294603903, 32'd4294785595, 32'd4294876445, 32'd4294921870};
      t = (e * 64'd94548) >> 16;
      n = t >> 16;
      acc = 64'd1 << 32;
      for (int k = 0; k < 16; k++) begin
         if (t[15-k]) acc = (acc * tab[k]) >> 32;
      end
      if (n > 40) return 16'd0;
      acc = acc >> n;
      r = (acc + (64'd1 << 15)) >> 16;
      return r > 64'hFFFF ? 16'hFFFF : r[15:0];
   endfunction

   function automatic affinity_type predict_affinity(box_pair_type b);
      affinity_type a;
      logic [63:0]  pos, shp, e;
      if (b.det_width == 0 || b.det_height == 0) begin
         a.affinity = 16'd0;
         a.invalid_box = 1'b1;
         return a;
      end
      pos = sq_offset(abs_diff(b.det_center_x, b.pred_center_x), b.det_width)
          + sq_offset(abs_diff(b.det_center_y, b.pred_center_y), b.det_height);
      pos = (pos * pos_weight) >> 8;
      shp = size_diff(b.det_width, b.pred_width) + size_diff(b.det_height, b.pred_height);
      shp = (shp * shp_weight) >> 8;
      e = pos + shp;
      if (e > 64'hFF_FFFF) e = 64'hFF_FFFF;
      a.affinity = neg_exp(e);
      a.invalid_box = 1'b0;
      return a;
   endfunction

   task automatic report_mismatch(string what, int got, int exp_v);
      $display("mismatch %s: got %0d, expected %0d (result %0d)", what, got, exp_v, n_got);
      errors++;
   endtask

   // receiver: random stall pattern, long hold-off on request
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL box_position_shape_affinity");
         $finish;
      end
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (long_stall > 0) begin
         rsp.ready <= 1'b0;
         long_stall <= long_stall - 1;
      end else begin
         rsp.ready <= !stall_en || ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      affinity_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_affinity.size() == 0) begin
            report_mismatch("unexpected word", int'(rsp.affinity), -1);
         end else begin
            e = pending_affinity.pop_front();
            if (rsp.affinity !== e.affinity)
               report_mismatch("affinity", int'(rsp.affinity), int'(e.affinity));
            if (rsp.invalid_box !== e.invalid_box)
               report_mismatch("invalid_box", int'(rsp.invalid_box), int'(e.invalid_box));
         end
         n_got++;
      end
   end

   task automatic send_pair(box_pair_type b, bit has_exp, affinity_type exp_a);
      affinity_type p;
      req.valid <= 1'b1;
      {req.det_center_x, req.det_center_y, req.det_width, req.det_height,
       req.pred_center_x, req.pred_center_y, req.pred_width, req.pred_height} <= b;
      do @(posedge clock); while (!req.ready);
      p = predict_affinity(b);
      if (has_exp && p != exp_a) report_mismatch("table vs predictor", int'(p), int'(exp_a));
      pending_affinity.push_back(p);
      if (p.invalid_box) n_invalid++;
      n_sent++;
   endtask

   task automatic idle_cycles(int n);
      req.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic write_reg(csr_reg_type idx, logic [11:0] v);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= v;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      if (idx == REG_POSITION_WEIGHT) pos_weight = v;
      else shp_weight = v;
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pending_affinity.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic box_pair_type random_pair(int mode);
      box_pair_type b;
      b = {$urandom, $urandom, $urandom, $urandom};
      if (mode == 0) begin
         b.det_width = 16'($urandom_range(16, 4000));
         b.det_height = 16'($urandom_range(16, 4000));
         b.pred_width = 16'(b.det_width + $urandom_range(0, 400) - 200);
         b.pred_height = 16'(b.det_height + $urandom_range(0, 400) - 200);
         b.pred_center_x = 16'(b.det_center_x + $urandom_range(0, 2 * b.det_width)
                         - b.det_width);
         b.pred_center_y = 16'(b.det_center_y + $urandom_range(0, 2 * b.det_height)
                         - b.det_height);
      end else if (mode == 1) begin
         if ($urandom_range(0, 1)) b.det_width = 0; else b.det_height = 0;
      end
      return b;
   endfunction

   typedef struct {
      box_pair_type b;
      bit           has_exp;
      affinity_type a;
   } dir_row_type;

   initial begin
      dir_row_type  rows[$];
      box_pair_type b;
      int           burst;
      int           mode;
      req.valid = 1'b0;
      {req.det_center_x, req.det_center_y, req.det_width, req.det_height,
       req.pred_center_x, req.pred_center_y, req.pred_width, req.pred_height} = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = REG_POSITION_WEIGHT;
      csr.data = '0;
      pos_weight = POSITION_WEIGHT_RST;
      shp_weight = SHAPE_WEIGHT_RST;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // exact match, invalid sizes, huge offsets, extremes
      rows.push_back('{'{100, 100, 50, 50, 100, 100, 50, 50}, 1, '{16'hFFFF, 1'b0}});
      rows.push_back('{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 16'hFFFF}, 1, '{16'hFFFF, 1'b0}});
      rows.push_back('{'{5, 5, 0, 9, 5, 5, 9, 9}, 1, '{16'd0, 1'b1}});
      rows.push_back('{'{5, 5, 9, 0, 5, 5, 9, 9}, 1, '{16'd0, 1'b1}});
      rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0}, 1, '{16'd0, 1'b1}});
      rows.push_back('{'{16'hFFFF, 0, 1, 1, 0, 16'hFFFF, 1, 1}, 1, '{16'd0, 1'b0}});
      rows.push_back('{'{1, 1, 1, 1, 1, 1, 0, 0}, 0, '{16'd0, 1'b0}});
      rows.push_back('{'{300, 200, 160, 320, 310, 190, 150, 330}, 0, '{16'd0, 1'b0}});
      rows.push_back('{'{0, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 0, 0, 16'hFFFF}, 0,
                       '{16'd0, 1'b0}});
      rows.push_back('{'{1000, 1000, 64, 64, 1032, 968, 80, 48}, 0, '{16'd0, 1'b0}});
      foreach (rows[i]) send_pair(rows[i].b, rows[i].has_exp, rows[i].a);
      drain();

      stall_en = 1'b1;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: begin
               write_reg(REG_POSITION_WEIGHT, 12'd0);
               write_reg(REG_SHAPE_WEIGHT, 12'd0);
            end
            2: begin
               write_reg(REG_POSITION_WEIGHT, 12'hFFF);
               write_reg(REG_SHAPE_WEIGHT, 12'hFFF);
            end
            3: begin
               write_reg(REG_POSITION_WEIGHT, 12'd1);
               write_reg(REG_SHAPE_WEIGHT, 12'hAAA);
            end
            4: begin
               write_reg(REG_POSITION_WEIGHT, 12'h555);
               write_reg(REG_SHAPE_WEIGHT, 12'd1);
            end
            5: begin
               write_reg(REG_POSITION_WEIGHT, 12'($urandom_range(0, 4095)));
               write_reg(REG_SHAPE_WEIGHT, 12'($urandom_range(0, 4095)));
            end
            default: ;
         endcase
         if (phase == 2) long_stall <= 300;
         for (int i = 0; i < 100; ) begin
            burst = $urandom_range(1, 20);
            for (int j = 0; j < burst && i < 100; j++, i++) begin
               if ($urandom_range(0, 9) < 7) mode = 0;
               else mode = ($urandom_range(0, 2) == 0) ? 1 : 2;
               b = random_pair(mode);
               send_pair(b, 1'b0, '0);
            end
            if (phase != 2 && $urandom_range(0, 1)) idle_cycles($urandom_range(1, 8));
         end
         if (phase == 3) begin
            req.valid <= 1'b0;
            while (pending_affinity.size() != 0) @(posedge clock);
         end
         drain();
      end

      $display("sent %0d box pairs (%0d invalid) under 6 weight settings, got %0d words",
               n_sent, n_invalid, n_got);
      $display("included a long output stall and a full drain pause mid-run");
      if (errors == 0) begin
         $display("PASS box_position_shape_affinity");
      end else begin
         $display("FAIL box_position_shape_affinity");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: box_position_shape_affinity.f
design/bpsa_pkg.sv
design/bpsa_req_if.sv
design/bpsa_rsp_if.sv
design/bpsa_csr_if.sv
design/bpsa_div.sv
design/bpsa_exp.sv
design/box_position_shape_affinity.sv
dv/tb_bpsa_if.sv
dv/tb_box_position_shape_affinity.sv
